>>> rtl/tpd_pkg.sv
package tpd_pkg;

    localparam int CAPACITY   = 64;
    localparam int COORD_BITS = 48;
    localparam int TOL_W      = 32;
    localparam int DIMS_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = ((COORD_BITS > TOL_W) ? COORD_BITS : TOL_W) + 2;

    localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(168);
    localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(3);

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_DIMS_USED = REG_IDX_W'(1);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } entry_t;

    typedef struct packed {
        logic   valid;
        logic   hit;
        entry_t pt;
    } probe_t;

    typedef struct packed {
        logic [TOL_W-1:0] tol;
        logic             use_y;
        logic             use_z;
    } cmp_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // True when |a - b| < tol for signed coordinates, evaluated without overflow.
    function automatic logic coord_close(input coord_t a, input coord_t b,
                                         input logic [TOL_W-1:0] tol);
        logic signed [CMP_W-1:0] d;
        logic signed [CMP_W-1:0] t;
        d = {{(CMP_W-COORD_BITS){a[COORD_BITS-1]}}, a}
          - {{(CMP_W-COORD_BITS){b[COORD_BITS-1]}}, b};
        t = {{(CMP_W-TOL_W){1'b0}}, tol};
        return (d < t) && (d > -t);
    endfunction

endpackage

>>> rtl/tpd_if.sv
interface tpd_in_if import tpd_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   start_of_set;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;

    modport source (output valid, output start_of_set, output coord_x, output coord_y,
                    output coord_z, input ready);
    modport sink   (input valid, input start_of_set, input coord_x, input coord_y,
                    input coord_z, output ready);
endinterface

interface tpd_out_if import tpd_pkg::*; ();
    logic              valid;
    logic              ready;
    coord_t            out_x;
    coord_t            out_y;
    coord_t            out_z;
    logic [SLOT_W-1:0] slot_index;
    logic              overflow;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output slot_index, output overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input slot_index, input overflow, output ready);
endinterface

>>> rtl/tpd_cell.sv
module tpd_cell import tpd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cmp_cfg_t cfg,
    input  logic     live,
    input  logic     wr_en,
    input  entry_t   wr_data,
    input  probe_t   probe_in,
    output probe_t   probe_out
);

    entry_t entry_reg;
    logic   valid_reg;
    logic   hit_reg;
    entry_t pt_reg;
    logic   match;
    logic   hit_next;

    always_comb
    begin
        match = coord_close(probe_in.pt.x, entry_reg.x, cfg.tol)
              && (!cfg.use_y || coord_close(probe_in.pt.y, entry_reg.y, cfg.tol))
              && (!cfg.use_z || coord_close(probe_in.pt.z, entry_reg.z, cfg.tol));
        hit_next = probe_in.hit || (live && match);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
        hit_reg <= hit_next;
        pt_reg  <= probe_in.pt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= probe_in.valid;
        end
    end

    assign probe_out = '{valid: valid_reg, hit: hit_reg, pt: pt_reg};

endmodule

>>> rtl/tolerance_point_dedup_unit.sv
// Tolerance-based duplicate point filter. Each point transaction is compared
// against every stored point of the current set by a chain of CAPACITY compare
// cells, one table entry per cell; the point walks the chain one cell per clock.
// An accepted point is registered into the launch register, passes every cell,
// and is held at the chain end before its result enters the output register;
// the next point is accepted only once that walk has finished.
// A finished result sits in an output register, so the block takes the next
// point while the result still waits; that point's own result is held back until
// the earlier one has been taken. Duplicates produce no result transaction.
// Configuration may be written only while no point is in flight.
module tolerance_point_dedup_unit import tpd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    tpd_in_if.sink                points,
    tpd_out_if.source             results
);

    state_t            state_reg;
    state_t            state_next;
    logic [TOL_W-1:0]  tol_reg;
    logic [DIMS_W-1:0] dims_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    probe_t            launch_reg;
    probe_t            launch_next;
    logic              hold_hit_reg;
    entry_t            hold_pt_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    entry_t            out_pt_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_ovf_reg;

    cmp_cfg_t          cfg;
    logic              accept;
    logic              chain_done;
    logic              finish_go;
    logic              table_full;
    logic              store_go;
    probe_t            chain [CAPACITY+1];
    logic [CAPACITY-1:0] live;
    logic [CAPACITY-1:0] cell_wr;
    logic [CAPACITY-1:0] chain_valid;

    always_comb
    begin
        cfg.tol   = tol_reg;
        cfg.use_y = (dims_reg >= DIMS_W'(2));
        cfg.use_z = (dims_reg == DIMS_W'(3));
    end

    assign accept     = points.valid && points.ready;
    assign chain_done = chain[CAPACITY].valid;
    assign table_full = (count_reg >= CNT_W'(CAPACITY));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (points.valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (chain_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (hold_hit_reg || !out_valid_reg || results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        points.ready = 1'b0;
        finish_go    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                points.ready = 1'b1;
            end
            ST_SEARCH:
            begin
                finish_go = 1'b0;
            end
            ST_FINISH:
            begin
                finish_go = !hold_hit_reg && (!out_valid_reg || results.ready);
            end
            default:
            begin
                points.ready = 1'b0;
            end
        endcase
    end

    assign store_go = finish_go && !table_full;

    always_comb
    begin
        launch_next.valid = accept;
        launch_next.hit   = 1'b0;
        launch_next.pt.x  = points.coord_x;
        launch_next.pt.y  = cfg.use_y ? points.coord_y : '0;
        launch_next.pt.z  = cfg.use_z ? points.coord_z : '0;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && points.start_of_set)
        begin
            count_next = '0;
        end
        else if (store_go)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_RESET;
            dims_reg      <= DIMS_RESET;
            count_reg     <= '0;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_TOLERANCE: tol_reg  <= wr_data[TOL_W-1:0];
                    REG_DIMS_USED: dims_reg <= wr_data[DIMS_W-1:0];
                    default:       tol_reg  <= tol_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_done)
        begin
            hold_hit_reg <= chain[CAPACITY].hit;
            hold_pt_reg  <= chain[CAPACITY].pt;
        end
        if (finish_go)
        begin
            out_pt_reg   <= hold_pt_reg;
            out_ovf_reg  <= table_full;
            out_slot_reg <= table_full ? '0 : SLOT_W'(count_reg);
        end
    end

    assign chain[0] = launch_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        assign live[g]        = (CNT_W'(g) < count_reg);
        assign cell_wr[g]     = store_go && (count_reg == CNT_W'(g));
        assign chain_valid[g] = chain[g+1].valid;

        tpd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg),
            .live      (live[g]),
            .wr_en     (cell_wr[g]),
            .wr_data   (hold_pt_reg),
            .probe_in  (chain[g]),
            .probe_out (chain[g+1])
        );
    end

    assign results.valid      = out_valid_reg;
    assign results.out_x      = out_pt_reg.x;
    assign results.out_y      = out_pt_reg.y;
    assign results.out_z      = out_pt_reg.z;
    assign results.slot_index = out_slot_reg;
    assign results.overflow   = out_ovf_reg;

    // Only one point may walk the cell chain at a time.
    a_single_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({chain_valid, launch_reg.valid}))
        else $error("more than one point in the compare chain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond table capacity");

    a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
        store_go |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("stored point did not advance the entry count");

    a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SEARCH) && launch_reg.valid)
        else $error("accepted point was not launched into the chain");

    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_done |-> state_reg == ST_SEARCH)
        else $error("chain finished outside of a search");

endmodule

>>> dv/tb_top.sv
module tb_top;
    import tpd_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    // Covers a point's walk through the chain; a duplicate leaves no result to wait for.
    localparam int SETTLE_CYCLES  = CAPACITY + 8;
    localparam int PHASE_POINTS   = 170;
    localparam int NUM_PHASES     = 7;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct {
        coord_t            x;
        coord_t            y;
        coord_t            z;
        logic [SLOT_W-1:0] slot;
        logic              ovf;
    } new_point_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    tpd_in_if  pts_if ();
    tpd_out_if res_if ();

    tolerance_point_dedup_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .points   (pts_if),
        .results  (res_if)
    );

    // Predictor state: configuration copy and the table of distinct points in the set.
    logic [TOL_W-1:0]  tol_cfg  = TOL_RESET;
    logic [DIMS_W-1:0] dims_cfg = DIMS_RESET;
    coord_t            seen_x [CAPACITY];
    coord_t            seen_y [CAPACITY];
    coord_t            seen_z [CAPACITY];
    int                seen_count = 0;
    new_point_t        pending_points [$];

    point_t set_history [$];
    int     points_left_in_set = 0;
    bit     long_set = 1'b0;
    bit     src_idle_on = 1'b1;
    bit     snk_idle_on = 1'b1;
    int     stall_left = 0;
    int     idle_cycles = 0;
    int     errors = 0;
    int     points_sent = 0;
    int     results_checked = 0;
    int     overflows_seen = 0;
    int     dups_dropped = 0;

    always #HALF_PERIOD clk = ~clk;

    function automatic bit coords_near(coord_t a, coord_t b, logic [TOL_W-1:0] tol);
        longint diff;
        diff = longint'($signed(a)) - longint'($signed(b));
        if (diff < 0)
            diff = -diff;
        return diff < longint'(tol);
    endfunction

    function automatic void filter_point(logic sos, coord_t x, coord_t y, coord_t z);
        int         dims;
        bit         hit;
        new_point_t np;
        dims = (dims_cfg == 0) ? 1 : int'(dims_cfg);
        np.x = x;
        np.y = (dims >= 2) ? y : '0;
        np.z = (dims >= 3) ? z : '0;
        if (sos)
            seen_count = 0;
        hit = 1'b0;
        for (int i = 0; i < seen_count && !hit; i++)
        begin
            hit = coords_near(np.x, seen_x[i], tol_cfg)
                && (dims < 2 || coords_near(np.y, seen_y[i], tol_cfg))
                && (dims < 3 || coords_near(np.z, seen_z[i], tol_cfg));
        end
        if (hit)
        begin
            dups_dropped++;
            return;
        end
        if (seen_count < CAPACITY)
        begin
            seen_x[seen_count] = np.x;
            seen_y[seen_count] = np.y;
            seen_z[seen_count] = np.z;
            np.slot = SLOT_W'(seen_count);
            np.ovf  = 1'b0;
            seen_count++;
        end
        else
        begin
            np.slot = '0;
            np.ovf  = 1'b1;
        end
        pending_points.insert(pending_points.size(), np);
    endfunction

    function automatic coord_t fresh_coord();
        case ($urandom_range(0, 7))
            0: return coord_t'({$urandom(), $urandom()});
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return coord_t'(longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000);
        endcase
    endfunction

    // Offsets are biased to land just inside and just outside the tolerance.
    function automatic coord_t near_coord(coord_t base);
        longint tol;
        longint delta;
        tol = longint'(tol_cfg);
        case ($urandom_range(0, 9))
            0, 1, 2: delta = 0;
            3: delta = tol - 1;
            4: delta = 1 - tol;
            5: delta = (tol == 0) ? 0 : longint'($urandom_range(0, tol_cfg - 1));
            6: delta = (tol == 0) ? 0 : -longint'($urandom_range(0, tol_cfg - 1));
            7: delta = tol;
            8: delta = -tol;
            default: return fresh_coord();
        endcase
        return coord_t'(longint'($signed(base)) + delta);
    endfunction

    task automatic send_point(logic sos, coord_t x, coord_t y, coord_t z);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            pts_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pts_if.valid        <= 1'b1;
        pts_if.start_of_set <= sos;
        pts_if.coord_x      <= x;
        pts_if.coord_y      <= y;
        pts_if.coord_z      <= z;
        do
            @(posedge clk);
        while (!pts_if.ready);
        points_sent++;
        filter_point(sos, x, y, z);
        if (sos)
            set_history.delete();
        set_history.insert(set_history.size(), '{x, y, z});
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_TOLERANCE)
            tol_cfg = data[TOL_W-1:0];
        else if (idx == REG_DIMS_USED)
            dims_cfg = data[DIMS_W-1:0];
    endtask

    task automatic configure(logic [TOL_W-1:0] tol, logic [DIMS_W-1:0] dims);
        write_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
        // Only the low bits belong to the register; the rest carry noise.
        write_reg(REG_DIMS_USED, ($urandom() & ~CFG_DATA_W'(3)) | CFG_DATA_W'(dims));
    endtask

    task automatic wait_idle();
        pts_if.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_point(1'b1, '0, '0, '0);
        send_point(1'b0, coord_t'(167), coord_t'(-167), coord_t'(100));
        send_point(1'b0, coord_t'(168), '0, '0);
        send_point(1'b0, '0, '0, coord_t'(-168));
        send_point(1'b0, '1, '1, '1);
        send_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(1'b0, COORD_MAX - coord_t'(167), COORD_MAX, COORD_MAX);
        send_point(1'b1, '0, '0, '0);
    endtask

    task automatic test_tolerance_extremes();
        wait_idle();
        configure('0, 2'd3);
        // With zero tolerance even an identical point is new.
        send_point(1'b1, coord_t'(5), coord_t'(5), coord_t'(5));
        send_point(1'b0, coord_t'(5), coord_t'(5), coord_t'(5));
        wait_idle();
        configure('1, 2'd3);
        send_point(1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(1'b0, '0, '0, '0);
        send_point(1'b0, coord_t'(48'hFFFF_FFFE), '0, '0);
        send_point(1'b0, coord_t'(48'hFFFF_FFFF), '0, '0);
    endtask

    task automatic test_dims_used();
        wait_idle();
        configure(TOL_RESET, 2'd1);
        send_point(1'b1, coord_t'(5), coord_t'(100), coord_t'(200));
        send_point(1'b0, coord_t'(5), coord_t'(-7), coord_t'(9));
        // The set continues across each change of dims_used.
        wait_idle();
        configure(TOL_RESET, 2'd2);
        send_point(1'b0, coord_t'(5), coord_t'(999), '0);
        send_point(1'b0, coord_t'(5), '0, coord_t'(12345));
        wait_idle();
        configure(TOL_RESET, 2'd0);
        send_point(1'b0, coord_t'(5), COORD_MAX, COORD_MIN);
        wait_idle();
        configure(TOL_RESET, 2'd3);
        send_point(1'b0, coord_t'(5), '0, '0);
        send_point(1'b0, coord_t'(5), '0, coord_t'(500));
    endtask

    task automatic test_full_table();
        coord_t first_y;
        coord_t first_z;
        wait_idle();
        configure(TOL_RESET, 2'd3);
        first_y = fresh_coord();
        first_z = fresh_coord();
        send_point(1'b1, '0, first_y, first_z);
        for (int i = 1; i < CAPACITY + 4; i++)
            send_point(1'b0, coord_t'(longint'(i) <<< 24), fresh_coord(), fresh_coord());
        // A full table is still searched, so a near copy stays a duplicate.
        send_point(1'b0, coord_t'(5), first_y, first_z);
        send_point(1'b1, COORD_MIN, '0, '0);
    endtask

    task automatic run_random_points(int count);
        logic   sos;
        point_t base;
        for (int n = 0; n < count; n++)
        begin
            sos = 1'b0;
            if (points_left_in_set == 0)
            begin
                long_set = ($urandom_range(0, 9) == 0);
                points_left_in_set = long_set ? $urandom_range(90, 110) : $urandom_range(1, 40);
                sos = 1'b1;
            end
            points_left_in_set--;
            if (!sos && set_history.size() > 0
                && $urandom_range(0, long_set ? 5 : 1) == 0)
            begin
                base = set_history[$urandom_range(0, set_history.size() - 1)];
                send_point(sos, near_coord(base.x), near_coord(base.y), near_coord(base.z));
            end
            else
            begin
                send_point(sos, fresh_coord(), fresh_coord(), fresh_coord());
            end
        end
    endtask

    task automatic test_random_phases();
        logic [TOL_W-1:0]  tol;
        logic [DIMS_W-1:0] dims;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin tol = TOL_RESET;                  dims = 2'd3; end
                1: begin tol = '0;                         dims = 2'd3; end
                2: begin tol = $urandom_range(1, 4096);    dims = 2'd2; end
                3: begin tol = $urandom();                 dims = 2'd1; end
                4: begin tol = '1;                         dims = 2'd3; end
                5: begin tol = $urandom_range(1, 65535);   dims = 2'd0; end
                default: begin tol = $urandom_range(100, 100000); dims = 2'd3; end
            endcase
            wait_idle();
            if (p == NUM_PHASES - 1)
            begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end
            else
            begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                snk_idle_on = ($urandom_range(0, 3) != 0);
            end
            configure(tol, dims);
            run_random_points(PHASE_POINTS);
        end
    endtask

    // Result side: random stalls and comparison against the oldest expected point.
    always @(posedge clk)
    begin : result_check
        new_point_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result transaction with no new point expected");
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                results_checked++;
                if (want.ovf)
                    overflows_seen++;
                if (res_if.out_x !== want.x)
                begin
                    $error("out_x expected %h got %h", want.x, res_if.out_x);
                    errors++;
                end
                if (res_if.out_y !== want.y)
                begin
                    $error("out_y expected %h got %h", want.y, res_if.out_y);
                    errors++;
                end
                if (res_if.out_z !== want.z)
                begin
                    $error("out_z expected %h got %h", want.z, res_if.out_z);
                    errors++;
                end
                if (res_if.slot_index !== want.slot)
                begin
                    $error("slot_index expected %0d got %0d", want.slot, res_if.slot_index);
                    errors++;
                end
                if (res_if.overflow !== want.ovf)
                begin
                    $error("overflow expected %b got %b", want.ovf, res_if.overflow);
                    errors++;
                end
            end
        end
        if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left--;
        end
        else if (snk_idle_on && $urandom_range(0, 5) == 0)
        begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
        end
        else
        begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pts_if.valid && pts_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        wr_en               <= 1'b0;
        wr_index            <= '0;
        wr_data             <= '0;
        pts_if.valid        <= 1'b0;
        pts_if.start_of_set <= 1'b0;
        pts_if.coord_x      <= '0;
        pts_if.coord_y      <= '0;
        pts_if.coord_z      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_tolerance_extremes();
        test_dims_used();
        test_full_table();
        test_random_phases();
        wait_idle();

        $display("%0d points sent: %0d new points checked, %0d of them overflowed, %0d duplicates",
                 points_sent, results_checked, overflows_seen, dups_dropped);
        $display("tolerance ran from zero to all ones with one to three coordinates compared");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
